FILE: rtl/rsk_pkg.sv
package rsk_pkg;

  // capacity of the sorting chain, one cell per record
  localparam int MAX_RECORDS = 64;

  // width of the load and drain counters, able to hold MAX_RECORDS itself
  localparam int CNT_W = $clog2(MAX_RECORDS + 1);

  // configured count register
  localparam int CFG_W = 7;
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  // common width for comparing the configured count against capacity
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  // one input word
  typedef struct packed {
    logic signed [31:0] sort_key;
    logic [15:0]        record_tag;
  } in_word_t;

  // one result word
  typedef struct packed {
    logic signed [31:0] sorted_key;
    logic [15:0]        sorted_tag;
    logic               last_result;
  } out_word_t;

  // contents of one cell
  typedef struct packed {
    logic     valid;
    in_word_t rec;
  } cell_t;

  // chain control, common to every cell
  typedef struct packed {
    logic insert;
    logic shift;
  } ctl_t;

endpackage

FILE: rtl/rsk_cell.sv
module rsk_cell (
  input  logic              clk,
  input  logic              rst,
  input  rsk_pkg::ctl_t     ctl,
  input  rsk_pkg::in_word_t in_rec,
  input  rsk_pkg::cell_t    left_cell,
  input  logic              left_gt,
  input  rsk_pkg::cell_t    right_cell,
  output rsk_pkg::cell_t    held,
  output logic              gt
);

  // an empty cell counts as larger than any key; ties keep load order
  assign gt = !held.valid || (held.rec.sort_key > in_rec.sort_key);

  // occupancy and record: take the new word, pass one along on insert, or drain leftwards
  always_ff @(posedge clk) begin
    if (rst) begin
      held.valid <= 1'b0;
    end else if (ctl.insert) begin
      if (gt) begin
        held.valid <= left_gt ? left_cell.valid : 1'b1;
        held.rec   <= left_gt ? left_cell.rec : in_rec;
      end
    end else if (ctl.shift) begin
      held <= right_cell;
    end
  end

endmodule

FILE: rtl/record_sort_by_key.sv
// Loads one word per cycle while not busy into a chain of compare-and-insert cells, kept sorted as it fills.
// The word that completes the batch is taken in, and the smallest key appears on the next cycle.
// Then one result per cycle until the batch is drained.
// busy is high while draining; no word is taken then, and results cannot be held off.
// Synchronous reset empties the chain, clears the load count and sets the count to 64.
module record_sort_by_key (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr,
  input  logic [rsk_pkg::CFG_W-1:0]        cfg_data,
  input  logic                             start,
  input  rsk_pkg::in_word_t                in_word,
  output logic                             busy,
  output logic                             strobe,
  output rsk_pkg::out_word_t               out_word
);

  logic [rsk_pkg::CFG_W-1:0] record_count;
  logic [rsk_pkg::CNT_W-1:0] loaded;
  logic [rsk_pkg::CNT_W-1:0] remaining;
  logic                      draining;

  logic [rsk_pkg::CNT_W-1:0] loaded_inc;
  logic [rsk_pkg::CNT_W-1:0] batch_n;
  logic [rsk_pkg::CMP_W-1:0] cfg_ext;
  logic                      accept;
  logic                      complete;
  rsk_pkg::ctl_t             ctl;

  rsk_pkg::cell_t cells   [rsk_pkg::MAX_RECORDS];
  logic           gts     [rsk_pkg::MAX_RECORDS];
  rsk_pkg::cell_t lcell   [rsk_pkg::MAX_RECORDS];
  logic           lgt     [rsk_pkg::MAX_RECORDS];
  rsk_pkg::cell_t rcell   [rsk_pkg::MAX_RECORDS];

  // count register
  always_ff @(posedge clk) begin
    if (rst) begin
      record_count <= rsk_pkg::CFG_RESET;
    end else if (cfg_wr) begin
      record_count <= cfg_data;
    end
  end

  // batch size: zero acts as one, anything over capacity saturates
  assign cfg_ext = rsk_pkg::CMP_W'(record_count);
  always_comb begin
    priority if (record_count == '0) begin
      batch_n = rsk_pkg::CNT_W'(1);
    end else if (cfg_ext > rsk_pkg::CMP_W'(rsk_pkg::MAX_RECORDS)) begin
      batch_n = rsk_pkg::CNT_W'(rsk_pkg::MAX_RECORDS);
    end else begin
      batch_n = rsk_pkg::CNT_W'(cfg_ext);
    end
  end

  assign busy       = draining;
  assign accept     = start && !busy;
  assign loaded_inc = loaded + rsk_pkg::CNT_W'(1);
  assign complete   = accept && (loaded_inc >= batch_n);

  // load and drain counters
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded    <= '0;
      draining  <= 1'b0;
      remaining <= '0;
    end else if (draining) begin
      remaining <= remaining - rsk_pkg::CNT_W'(1);
      if (remaining == rsk_pkg::CNT_W'(1)) begin
        draining <= 1'b0;
      end
    end else if (accept) begin
      if (complete) begin
        loaded    <= '0;
        draining  <= 1'b1;
        remaining <= loaded_inc;
      end else begin
        loaded <= loaded_inc;
      end
    end
  end

  assign ctl.insert = accept;
  assign ctl.shift  = draining;

  // sorting chain
  for (genvar i = 0; i < rsk_pkg::MAX_RECORDS; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign lcell[i] = '0;
      assign lgt[i]   = 1'b0;
    end else begin : g_mid
      assign lcell[i] = cells[i-1];
      assign lgt[i]   = gts[i-1];
    end
    if (i == rsk_pkg::MAX_RECORDS - 1) begin : g_last
      assign rcell[i] = '0;
    end else begin : g_inner
      assign rcell[i] = cells[i+1];
    end

    rsk_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .in_rec     (in_word),
      .left_cell  (lcell[i]),
      .left_gt    (lgt[i]),
      .right_cell (rcell[i]),
      .held       (cells[i]),
      .gt         (gts[i])
    );
  end

  // result word comes straight from the head cell
  assign strobe               = draining;
  assign out_word.sorted_key  = cells[0].rec.sort_key;
  assign out_word.sorted_tag  = cells[0].rec.record_tag;
  assign out_word.last_result = (remaining == rsk_pkg::CNT_W'(1));

  // head cell must hold a record whenever a word goes out
  a_head_valid: assert property (@(posedge clk) disable iff (rst)
    draining |-> cells[0].valid)
    else $error("drain with empty head cell");

  // the first two cells stay in order
  a_head_order: assert property (@(posedge clk) disable iff (rst)
    cells[1].valid |-> (cells[0].valid && cells[0].rec.sort_key <= cells[1].rec.sort_key))
    else $error("chain out of order");

  // completing a batch starts the drain on the next cycle
  a_drain_start: assert property (@(posedge clk) disable iff (rst)
    complete |=> strobe)
    else $error("batch completed without output");

  // after the last word the block is free and the head cell is empty
  a_drain_end: assert property (@(posedge clk) disable iff (rst)
    (strobe && out_word.last_result) |=> (!busy && !cells[0].valid))
    else $error("chain not empty after last word");

endmodule
